// ----- rtl/hete_pkg.sv -----
`default_nettype none

package hete_pkg;

   // Tab stop spacing in columns (1 to 6).
   localparam int TAB_WIDTH = 4;

   // Column counter width: enough for 0 .. TAB_WIDTH-1.
   localparam int COL_W = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;

   // Run length counter width: runs are 1 to 6 bytes long.
   localparam int LEN_W = 3;

   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_QUOT  = 8'h22;
   localparam logic [7:0] CHAR_AMP   = 8'h26;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_LT    = 8'h3C;
   localparam logic [7:0] CHAR_GT    = 8'h3E;
   localparam logic [7:0] CHAR_A     = 8'h61;
   localparam logic [7:0] CHAR_G     = 8'h67;
   localparam logic [7:0] CHAR_L     = 8'h6C;
   localparam logic [7:0] CHAR_M     = 8'h6D;
   localparam logic [7:0] CHAR_O     = 8'h6F;
   localparam logic [7:0] CHAR_P     = 8'h70;
   localparam logic [7:0] CHAR_Q     = 8'h71;
   localparam logic [7:0] CHAR_T     = 8'h74;
   localparam logic [7:0] CHAR_U     = 8'h75;

   localparam logic [LEN_W-1:0] LEN_LT_GT = 3'd4;
   localparam logic [LEN_W-1:0] LEN_AMP   = 3'd5;
   localparam logic [LEN_W-1:0] LEN_QUOT  = 3'd6;
   localparam logic [LEN_W-1:0] LEN_PLAIN = 3'd1;

   // One output byte with its end-of-run flag.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } beat_type;

   // Byte idx of the escaped form of src (tabs give spaces).
   function automatic logic [7:0] escape_char(input logic [7:0] src,
                                              input logic [LEN_W-1:0] idx);
      logic [7:0] res;
      res = src;
      case (src)
         CHAR_LT, CHAR_GT: begin
            case (idx)
               3'd0:    res = CHAR_AMP;
               3'd1:    res = (src == CHAR_LT) ? CHAR_L : CHAR_G;
               3'd2:    res = CHAR_T;
               default: res = CHAR_SEMI;
            endcase
         end
         CHAR_AMP: begin
            case (idx)
               3'd0:    res = CHAR_AMP;
               3'd1:    res = CHAR_A;
               3'd2:    res = CHAR_M;
               3'd3:    res = CHAR_P;
               default: res = CHAR_SEMI;
            endcase
         end
         CHAR_QUOT: begin
            case (idx)
               3'd0:    res = CHAR_AMP;
               3'd1:    res = CHAR_Q;
               3'd2:    res = CHAR_U;
               3'd3:    res = CHAR_O;
               3'd4:    res = CHAR_T;
               default: res = CHAR_SEMI;
            endcase
         end
         CHAR_TAB: res = CHAR_SPACE;
         default:  res = src;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/hete_item_stage.sv -----
`default_nettype none

// Input register, column tracking and the run sequencer. Each accepted
// byte is held here while its run of output bytes is handed downstream,
// one byte per cycle that the output stage can take.
module hete_item_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic [7:0]        in_byte,
   input  wire logic              starts_text,
   output logic                   beat_valid,
   input  wire logic              beat_ready,
   output hete_pkg::beat_type     beat
);

   logic                             hold_valid_ff, hold_valid_in;
   logic [7:0]                       hold_byte_ff, hold_byte_in;
   logic [hete_pkg::LEN_W-1:0]       hold_len_ff, hold_len_in;
   logic [hete_pkg::LEN_W-1:0]       hold_idx_ff, hold_idx_in;
   logic [hete_pkg::COL_W-1:0]       column_in_stop_ff, column_in_stop_in;

   logic                             accept;
   logic                             advance;
   logic                             run_done;
   logic [hete_pkg::COL_W-1:0]       col_start;
   logic [hete_pkg::LEN_W-1:0]       run_len;
   logic                             counts_column;

   assign run_done   = (hold_idx_ff == hold_len_ff - hete_pkg::LEN_W'(1));
   assign beat_valid = hold_valid_ff;
   assign advance    = hold_valid_ff && beat_ready;
   assign in_ready   = !hold_valid_ff || (advance && run_done);
   assign accept     = in_valid && in_ready;

   assign beat.data = hete_pkg::escape_char(hold_byte_ff, hold_idx_ff);
   assign beat.last = run_done;

   // ASCII bytes and UTF-8 lead bytes take a column; continuation bytes don't.
   assign counts_column = !in_byte[7] || (in_byte[7:6] == 2'b11);
   assign col_start     = starts_text ? '0 : column_in_stop_ff;

   always_comb begin
      case (in_byte)
         hete_pkg::CHAR_LT, hete_pkg::CHAR_GT: run_len = hete_pkg::LEN_LT_GT;
         hete_pkg::CHAR_AMP:                   run_len = hete_pkg::LEN_AMP;
         hete_pkg::CHAR_QUOT:                  run_len = hete_pkg::LEN_QUOT;
         hete_pkg::CHAR_TAB:
            run_len = hete_pkg::LEN_W'(hete_pkg::TAB_WIDTH)
                      - hete_pkg::LEN_W'(col_start);
         default:                              run_len = hete_pkg::LEN_PLAIN;
      endcase
   end

   always_comb begin
      hold_valid_in     = hold_valid_ff;
      hold_byte_in      = hold_byte_ff;
      hold_len_in       = hold_len_ff;
      hold_idx_in       = hold_idx_ff;
      column_in_stop_in = column_in_stop_ff;
      if (advance) begin
         hold_idx_in = hold_idx_ff + hete_pkg::LEN_W'(1);
         if (run_done) begin
            hold_valid_in = 1'b0;
         end
      end
      if (accept) begin
         hold_valid_in = 1'b1;
         hold_byte_in  = in_byte;
         hold_len_in   = run_len;
         hold_idx_in   = '0;
         if (in_byte == hete_pkg::CHAR_TAB) begin
            column_in_stop_in = '0;
         end else if (counts_column) begin
            if (col_start == hete_pkg::COL_W'(hete_pkg::TAB_WIDTH - 1)) begin
               column_in_stop_in = '0;
            end else begin
               column_in_stop_in = col_start + hete_pkg::COL_W'(1);
            end
         end else begin
            column_in_stop_in = col_start;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff     <= 1'b0;
         column_in_stop_ff <= '0;
      end else begin
         hold_valid_ff     <= hold_valid_in;
         column_in_stop_ff <= column_in_stop_in;
      end
      hold_byte_ff <= hold_byte_in;
      hold_len_ff  <= hold_len_in;
      hold_idx_ff  <= hold_idx_in;
   end

endmodule

`default_nettype wire

// ----- rtl/hete_out_stage.sv -----
`default_nettype none

// Result register. It takes a new byte whenever it is empty or its
// current byte is being taken in the same cycle.
module hete_out_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              beat_valid,
   output logic                   beat_ready,
   input  wire hete_pkg::beat_type beat,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output hete_pkg::beat_type     out_beat
);

   logic               valid_ff, valid_in;
   hete_pkg::beat_type beat_ff, beat_in;

   assign beat_ready = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign out_beat   = beat_ff;

   always_comb begin
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (beat_ready) begin
         valid_in = beat_valid;
         beat_in  = beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      beat_ff <= beat_in;
   end

endmodule

`default_nettype wire

// ----- rtl/html_escape_tab_expand_unit.sv -----
// Channel     Dir  Handshake          Payload
// req_        in   tvalid / tready    tdata = in_byte, tuser = starts_text
// rsp_        out  tvalid / tready    tdata = out_byte, tlast = last_of_run
//
// A plain byte gives one output byte; an input byte that expands to N output
// bytes (entities: 4 to 6, tabs: 1 to TAB_WIDTH) holds the input until its
// run is done, one output byte per cycle while the result side does not stall.
// The single run sequencer walks each run.
// Reset is synchronous and active high; it clears the column count.
// A stall on the result side stops the sequencer, but a new input
// transaction is still taken while the last result byte waits.
`default_nettype none

module html_escape_tab_expand_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_byte
   input  wire logic       req_tuser,   // [0] starts_text
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_byte
   output logic            rsp_tlast
);

   // Byte stream between the sequencer and the result register.
   logic               beat_valid;
   logic               beat_ready;
   hete_pkg::beat_type beat;
   hete_pkg::beat_type out_beat;

   // The sequencer holds one input byte, tracks the column within the
   // current tab stop and walks the bytes of its escaped form.
   hete_item_stage u_item (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_byte     (req_tdata),
      .starts_text (req_tuser),
      .beat_valid  (beat_valid),
      .beat_ready  (beat_ready),
      .beat        (beat)
   );

   // The result register decouples the output handshake from the sequencer.
   hete_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (beat_valid),
      .beat_ready (beat_ready),
      .beat       (beat),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_beat   (out_beat)
   );

   assign rsp_tdata = out_beat.data;
   assign rsp_tlast = out_beat.last;

endmodule

`default_nettype wire

// ----- rtl/hete_checker.sv -----
`default_nettype none

module hete_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic [7:0] req_tdata,
   input wire logic       req_tuser,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tlast
);

   // A stalled result holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // An accepted escaped character leaves the input not ready, as its run is still in the sequencer.
   a_entity_holds: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tdata == hete_pkg::CHAR_LT
                                   || req_tdata == hete_pkg::CHAR_GT
                                   || req_tdata == hete_pkg::CHAR_AMP
                                   || req_tdata == hete_pkg::CHAR_QUOT)
      |=> !req_tready)
      else $error("input taken during an entity run");

   // A run that is not finished continues in the next cycle without a gap.
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("gap inside an output run");

endmodule

bind html_escape_tab_expand_unit hete_checker u_hete_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ----- dv/tb_html_escape_tab_expand_unit.sv -----
`timescale 1ns / 100ps

// Self-checking testbench for the HTML escaping and tab expansion unit.
// Every input transaction is run through a predictor in the testbench, which
// keeps its own copy of the column count. The predictor appends the output
// bytes that the transaction should cause to a queue. A monitor pops that
// queue on every output transaction and compares byte and end-of-run flag.
module tb_html_escape_tab_expand_unit;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 8;
   localparam int RANDOM_ITEMS   = 230;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;  // [7:0] in_byte
   logic       req_tuser  = 1'b0;   // [0] starts_text
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_byte
   logic       rsp_tlast;           // last_of_run

   // Output bytes that are still owed by the unit, oldest first.
   hete_pkg::beat_type expected_beats[$];

   // Column within the current tab stop, one bit wider than the unit needs
   // so that reaching TAB_WIDTH can be seen before the wrap.
   logic [hete_pkg::COL_W:0] column;

   int mismatches = 0;
   int idle_cycles = 0;

   // State of the sender's burst and gap pattern.
   int burst_left = 4;

   // State of the receiver's stall pattern.
   int stall_mode = 0;
   int stall_span = 0;
   int stall_tick = 0;

   html_escape_tab_expand_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Works out the escaped form of one accepted input byte and queues it.
   // Entities count as one column and tabs move to the next stop; continuation bytes count as none.
   function automatic void expand_byte(input logic [7:0] src, input logic starts_text);
      string              entity;
      logic [7:0]         run[$];
      hete_pkg::beat_type beat;
      int                 spaces;
      entity = "";
      if (starts_text) begin
         column = '0;
      end
      if (column >= hete_pkg::TAB_WIDTH) begin
         column = '0;
      end
      case (src)
         hete_pkg::CHAR_LT:   entity = "&lt;";
         hete_pkg::CHAR_GT:   entity = "&gt;";
         hete_pkg::CHAR_AMP:  entity = "&amp;";
         hete_pkg::CHAR_QUOT: entity = "&quot;";
         hete_pkg::CHAR_TAB: begin
            spaces = hete_pkg::TAB_WIDTH - int'(column);
            for (int i = 0; i < spaces; i++) begin
               run.push_back(hete_pkg::CHAR_SPACE);
            end
         end
         default:   run.push_back(src);
      endcase
      for (int i = 0; i < entity.len(); i++) begin
         run.push_back(entity[i]);
      end
      for (int i = 0; i < run.size(); i++) begin
         beat.data = run[i];
         beat.last = (i == run.size() - 1);
         expected_beats.push_back(beat);
      end
      // Tabs land on a stop; ASCII and UTF-8 lead bytes take one column.
      if (src == hete_pkg::CHAR_TAB) begin
         column = '0;
      end else if (!src[7] || src[7:6] == 2'b11) begin
         column = column + 1'b1;
         if (column >= hete_pkg::TAB_WIDTH) begin
            column = '0;
         end
      end
   endfunction

   task automatic report_mismatch(input string what, input int exp_val, input int got_val);
      $display("[%0t] mismatch on %s: expected 0x%02h, got 0x%02h",
               $time, what, exp_val, got_val);
      mismatches++;
   endtask

   // Presents one byte and holds it until the unit takes it. The predictor
   // runs at the accepting edge, so the expectation is always queued before
   // the first output byte can leave the hold and result registers.
   task automatic send_byte(input logic [7:0] src, input logic starts_text);
      req_tvalid <= 1'b1;
      req_tdata  <= src;
      req_tuser  <= starts_text;
      do begin
         @(posedge clock);
      end while (!req_tready);
      expand_byte(src, starts_text);
   endtask

   // Sends one byte inside the burst pattern. At the end of a burst the
   // sender drops valid for a random gap; a gap of zero keeps the stream
   // running back to back, and now and then a long burst has no gaps at all.
   task automatic push_byte(input logic [7:0] src, input logic starts_text);
      int gap;
      send_byte(src, starts_text);
      burst_left--;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
         burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            req_tdata  <= 8'($urandom);
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Stops sending until every owed output byte has come back.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (expected_beats.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Each entity on its own, the first one opening a new text.
   task automatic test_entities();
      push_byte(hete_pkg::CHAR_LT, 1'b1);
      push_byte(hete_pkg::CHAR_GT, 1'b0);
      push_byte(hete_pkg::CHAR_AMP, 1'b0);
      push_byte(hete_pkg::CHAR_QUOT, 1'b0);
      wait_for_drain();
   endtask

   // A tab from each column of a stop: four spaces from column zero down to
   // one space from the last column, then a tab right after a tab.
   task automatic test_tab_stops();
      for (int k = 0; k < hete_pkg::TAB_WIDTH; k++) begin
         for (int i = 0; i < k; i++) begin
            push_byte(8'h61 + 8'(i), (i == 0));
         end
         push_byte(hete_pkg::CHAR_TAB, (k == 0));
      end
      push_byte(hete_pkg::CHAR_TAB, 1'b0);
      wait_for_drain();
   endtask

   // A full stop of plain bytes wraps the column back to zero.
   task automatic test_column_wrap();
      for (int i = 0; i < hete_pkg::TAB_WIDTH; i++) begin
         push_byte(8'h77, (i == 0));
      end
      push_byte(hete_pkg::CHAR_TAB, 1'b0);
      wait_for_drain();
   endtask

   // Lead bytes advance the column and continuation bytes do not, whether
   // they follow a lead byte or stand alone. The byte extremes sit here too.
   task automatic test_utf8_columns();
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b0);
      push_byte(8'hBF, 1'b0);
      push_byte(hete_pkg::CHAR_TAB, 1'b0);
      push_byte(8'hC3, 1'b1);
      push_byte(8'hA9, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(hete_pkg::CHAR_TAB, 1'b0);
      wait_for_drain();
   endtask

   // A new text in the middle of a stop clears the column before the tab.
   task automatic test_new_text();
      push_byte(8'h78, 1'b0);
      push_byte(hete_pkg::CHAR_TAB, 1'b1);
      wait_for_drain();
   endtask

   // Random text. Most of it looks like real markup: printable ASCII, the
   // escaped characters, tabs and well-formed UTF-8 sequences. The rest is
   // any byte at all, which also covers stray continuation bytes.
   task automatic test_random_text();
      int         sent;
      int         trail;
      logic [7:0] src;
      logic       starts_text;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         starts_text = ($urandom_range(0, 19) == 0);
         case ($urandom_range(0, 19))
            0, 1, 2:  begin
               case ($urandom_range(0, 3))
                  0:       src = hete_pkg::CHAR_LT;
                  1:       src = hete_pkg::CHAR_GT;
                  2:       src = hete_pkg::CHAR_AMP;
                  default: src = hete_pkg::CHAR_QUOT;
               endcase
               push_byte(src, starts_text);
               sent++;
            end
            3, 4: begin
               push_byte(hete_pkg::CHAR_TAB, starts_text);
               sent++;
            end
            5, 6: begin
               // A lead byte followed by one to three continuation bytes.
               trail = $urandom_range(1, 3);
               case (trail)
                  1:       src = 8'hC0 | 8'($urandom_range(0, 8'h1F));
                  2:       src = 8'hE0 | 8'($urandom_range(0, 8'h0F));
                  default: src = 8'hF0 | 8'($urandom_range(0, 8'h0F));
               endcase
               push_byte(src, starts_text);
               for (int i = 0; i < trail; i++) begin
                  push_byte(8'h80 | 8'($urandom_range(0, 8'h3F)), 1'b0);
               end
               sent += trail + 1;
            end
            7: begin
               push_byte(8'($urandom), starts_text);
               sent++;
            end
            default: begin
               push_byte(8'($urandom_range(8'h20, 8'h7E)), starts_text);
               sent++;
            end
         endcase
         if ($urandom_range(0, 99) == 0) begin
            wait_for_drain();
         end
      end
      wait_for_drain();
   endtask

   // The receiver switches, after a random span, between always ready,
   // coin flips, mostly stalled and a fixed one-in-eight stall.
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_span <= $urandom_range(20, 80);
      end else begin
         stall_span <= stall_span - 1;
      end
      stall_tick <= stall_tick + 1;
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 1) == 1);
         2:       rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (stall_tick[2:0] != 3'd0);
      endcase
   end

   // Checks each output transaction against the oldest owed byte.
   always @(posedge clock) begin
      hete_pkg::beat_type owed;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_beats.size() == 0) begin
            report_mismatch("unexpected output byte", 0, int'(rsp_tdata));
         end else begin
            owed = expected_beats.pop_front();
            if (rsp_tdata !== owed.data) begin
               report_mismatch("out_byte", int'(owed.data), int'(rsp_tdata));
            end
            if (rsp_tlast !== owed.last) begin
               report_mismatch("last_of_run", int'(owed.last), int'(rsp_tlast));
            end
         end
      end
   end

   // Ends the run if neither side has moved a transaction for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      column = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_entities();
      test_tab_stops();
      test_column_wrap();
      test_utf8_columns();
      test_new_text();
      test_random_text();

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_beats.size() != 0) begin
         report_mismatch("bytes never delivered", expected_beats.size(), 0);
      end
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/hete_pkg.sv
rtl/hete_item_stage.sv
rtl/hete_out_stage.sv
rtl/html_escape_tab_expand_unit.sv
rtl/hete_checker.sv
dv/tb_html_escape_tab_expand_unit.sv
